@@ src/rms_pkg.sv @@
// ----------------------------------------------------------------------------
// rms_pkg
// Shared sizes, configuration codes and interface types of the RMS level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

    // Sizing
    localparam int CHANNELS    = 8;
    localparam int MAX_FRAMES  = 4096;
    localparam int SAMPLE_BITS = 24;

    // Fixed field widths
    localparam int CHAN_W   = 3;
    localparam int CCOUNT_W = 4;
    localparam int LEVEL_W  = 24;

    // Derived widths
    localparam int TALLY_W   = $clog2(MAX_FRAMES + 1);
    localparam int SQ_W      = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W     = SQ_W + TALLY_W - 1;
    localparam int SQRT_IN_W = 2 * SAMPLE_BITS;
    localparam int WORK_W    = (SUM_W > SQRT_IN_W) ? SUM_W : SQRT_IN_W;
    localparam int CNT_W     = $clog2(WORK_W + 1);
    localparam int RREM_W    = SAMPLE_BITS + 3;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CCOUNT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNNING       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;
    localparam logic [CCOUNT_W-1:0]  CCOUNT_RESET      = 4'd2;

    // Block summary passed from the accumulator to the merge stage
    typedef struct packed {
        logic [CHAN_W-1:0] ch;
        logic              in_p;
        logic              out_p;
        logic              ovf;
    } t_blk_info;

    // Lane status
    typedef struct packed {
        logic busy;
        logic done;
    } t_lane_st;

endpackage

`default_nettype wire

@@ src/rms_accum.sv @@
// ----------------------------------------------------------------------------
// rms_accum
// Front end: squares the samples, accumulates per side and counts frames.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_accum
    import rms_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_running,
    input  wire logic [CCOUNT_W-1:0]           i_channel_count,
    input  wire logic [CHAN_W-1:0]             i_channel,
    input  wire logic signed [SAMPLE_BITS-1:0] i_in_sample,
    input  wire logic                          i_in_present,
    input  wire logic signed [SAMPLE_BITS-1:0] i_out_sample,
    input  wire logic                          i_out_present,
    input  wire logic                          i_last_frame,
    input  wire logic                          i_release,
    output logic                               o_start,
    output t_blk_info                          o_info,
    output logic [SUM_W-1:0]                   o_in_sum,
    output logic [SUM_W-1:0]                   o_out_sum,
    output logic [TALLY_W-1:0]                 o_tally
);

    logic                   take;
    logic                   qualify;
    logic [SAMPLE_BITS-1:0] in_mag;
    logic [SAMPLE_BITS-1:0] out_mag;
    logic [2*SAMPLE_BITS-1:0] in_sq_full;
    logic [2*SAMPLE_BITS-1:0] out_sq_full;

    logic                   r_busy;
    logic                   r_a_vld;
    logic                   r_a_last;
    logic [CHAN_W-1:0]      r_a_ch;
    logic                   r_a_inp;
    logic                   r_a_outp;
    logic [SQ_W-1:0]        r_a_in_sq;
    logic [SQ_W-1:0]        r_a_out_sq;

    logic [SUM_W-1:0]       r_in_sum;
    logic [SUM_W-1:0]       r_out_sum;
    logic [TALLY_W-1:0]     r_tally;
    logic                   r_ovf;
    logic [SUM_W-1:0]       n_in_sum;
    logic [SUM_W-1:0]       n_out_sum;
    logic [TALLY_W-1:0]     n_tally;
    logic                   n_ovf;

    // Hold off only a last frame while the back end still owns a block
    assign o_ready = !r_busy || !i_last_frame;
    assign take    = i_valid && o_ready;
    assign qualify = i_running
                  && (CCOUNT_W'(i_channel) < i_channel_count)
                  && (int'(i_channel) < CHANNELS);

    assign in_mag      = i_in_sample[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-i_in_sample)
                                                     : SAMPLE_BITS'(i_in_sample);
    assign out_mag     = i_out_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_out_sample)
                                                     : SAMPLE_BITS'(i_out_sample);
    assign in_sq_full  = in_mag * in_mag;
    assign out_sq_full = out_mag * out_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= take && qualify;
            if (take && qualify && i_last_frame) begin
                r_busy <= 1'b1;
            end else if (i_release) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_last   <= i_last_frame;
        r_a_ch     <= i_channel;
        r_a_inp    <= i_in_present;
        r_a_outp   <= i_out_present;
        r_a_in_sq  <= SQ_W'(in_sq_full);
        r_a_out_sq <= SQ_W'(out_sq_full);
    end

    // Add this frame, or flag overflow once the tally is full
    always_comb begin
        n_in_sum  = r_in_sum;
        n_out_sum = r_out_sum;
        n_tally   = r_tally;
        n_ovf     = r_ovf;
        if (r_tally < TALLY_W'(MAX_FRAMES)) begin
            if (r_a_inp) begin
                n_in_sum = r_in_sum + SUM_W'(r_a_in_sq);
            end
            if (r_a_outp) begin
                n_out_sum = r_out_sum + SUM_W'(r_a_out_sq);
            end
            n_tally = r_tally + TALLY_W'(1);
        end else begin
            n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sum  <= '0;
            r_out_sum <= '0;
            r_tally   <= '0;
            r_ovf     <= 1'b0;
        end else if (r_a_vld) begin
            if (r_a_last) begin
                r_in_sum  <= '0;
                r_out_sum <= '0;
                r_tally   <= '0;
                r_ovf     <= 1'b0;
            end else begin
                r_in_sum  <= n_in_sum;
                r_out_sum <= n_out_sum;
                r_tally   <= n_tally;
                r_ovf     <= n_ovf;
            end
        end
    end

    assign o_start      = r_a_vld && r_a_last;
    assign o_in_sum     = n_in_sum;
    assign o_out_sum    = n_out_sum;
    assign o_tally      = n_tally;
    assign o_info.ch    = r_a_ch;
    assign o_info.in_p  = r_a_inp;
    assign o_info.out_p = r_a_outp;
    assign o_info.ovf   = n_ovf;

endmodule

`default_nettype wire

@@ src/rms_lane.sv @@
// ----------------------------------------------------------------------------
// rms_lane
// One side's back end: restoring divide of sum by tally, then digit square root.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_lane
    import rms_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [SUM_W-1:0]       i_dividend,
    input  wire logic [TALLY_W-1:0]     i_divisor,
    input  wire logic                   i_ack,
    output t_lane_st                    o_st,
    output logic [SAMPLE_BITS-1:0]      o_root
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_SQRT = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]             r_phase;
    logic [1:0]             n_phase;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic [WORK_W-1:0]      r_work;
    logic [WORK_W-1:0]      n_work;
    logic [TALLY_W-1:0]     r_dvs;
    logic [TALLY_W-1:0]     n_dvs;
    logic [TALLY_W-1:0]     r_rem;
    logic [TALLY_W-1:0]     n_rem;
    logic [SAMPLE_BITS-1:0] r_root;
    logic [SAMPLE_BITS-1:0] n_root;
    logic [RREM_W-1:0]      r_srem;
    logic [RREM_W-1:0]      n_srem;

    logic [TALLY_W:0]       rem_sh;
    logic [RREM_W-1:0]      srem_sh;
    logic [RREM_W-1:0]      trial;

    assign rem_sh  = {r_rem, r_work[WORK_W-1]};
    assign srem_sh = {r_srem[RREM_W-3:0], r_work[SQRT_IN_W-1 -: 2]};
    assign trial   = RREM_W'({r_root, 2'b01});

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_work  = r_work;
        n_dvs   = r_dvs;
        n_rem   = r_rem;
        n_root  = r_root;
        n_srem  = r_srem;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_work  = WORK_W'(i_dividend);
                    n_dvs   = i_divisor;
                    n_rem   = '0;
                    n_cnt   = CNT_W'(WORK_W);
                    n_phase = PH_DIV;
                end
            end
            PH_DIV: begin
                // one quotient bit per cycle, shifted into the freed low end
                if (rem_sh >= {1'b0, r_dvs}) begin
                    n_rem  = TALLY_W'(rem_sh - {1'b0, r_dvs});
                    n_work = {r_work[WORK_W-2:0], 1'b1};
                end else begin
                    n_rem  = TALLY_W'(rem_sh);
                    n_work = {r_work[WORK_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_cnt   = CNT_W'(SAMPLE_BITS);
                    n_root  = '0;
                    n_srem  = '0;
                    n_phase = PH_SQRT;
                end
            end
            PH_SQRT: begin
                // one root bit per cycle from two radicand bits
                if (srem_sh >= trial) begin
                    n_srem = srem_sh - trial;
                    n_root = {r_root[SAMPLE_BITS-2:0], 1'b1};
                end else begin
                    n_srem = srem_sh;
                    n_root = {r_root[SAMPLE_BITS-2:0], 1'b0};
                end
                n_work = {r_work[WORK_W-3:0], 2'b00};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                if (i_ack) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_work <= n_work;
        r_dvs  <= n_dvs;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_srem <= n_srem;
    end

    assign o_st.busy = (r_phase != PH_IDLE);
    assign o_st.done = (r_phase == PH_DONE);
    assign o_root    = r_root;

endmodule

`default_nettype wire

@@ src/rms_merge.sv @@
// ----------------------------------------------------------------------------
// rms_merge
// Merge stage: joins both lanes, updates the level stores, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_merge
    import rms_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire t_blk_info              i_info,
    input  wire t_lane_st               i_in_st,
    input  wire t_lane_st               i_out_st,
    input  wire logic [SAMPLE_BITS-1:0] i_in_root,
    input  wire logic [SAMPLE_BITS-1:0] i_out_root,
    output logic                        o_ack,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [CHAN_W-1:0]           o_level_channel,
    output logic [LEVEL_W-1:0]          o_input_level,
    output logic [LEVEL_W-1:0]          o_output_level,
    output logic                        o_overflow
);

    t_blk_info             r_info;
    logic [LEVEL_W-1:0]    r_in_store  [CHANNELS];
    logic [LEVEL_W-1:0]    r_out_store [CHANNELS];
    logic                  r_out_vld;
    logic [CHAN_W-1:0]     r_out_ch;
    logic [LEVEL_W-1:0]    r_out_in_lvl;
    logic [LEVEL_W-1:0]    r_out_out_lvl;
    logic                  r_out_ovf;

    logic [CH_IDX_W-1:0]   wr_idx;
    logic                  load;
    logic [LEVEL_W-1:0]    n_in_lvl;
    logic [LEVEL_W-1:0]    n_out_lvl;

    assign wr_idx    = CH_IDX_W'(r_info.ch);
    assign load      = i_in_st.done && i_out_st.done && (!r_out_vld || i_ready);
    // absent side keeps its stored level
    assign n_in_lvl  = r_info.in_p  ? LEVEL_W'(i_in_root)  : r_in_store[wr_idx];
    assign n_out_lvl = r_info.out_p ? LEVEL_W'(i_out_root) : r_out_store[wr_idx];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_info <= i_info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_in_store[k]  <= '0;
                r_out_store[k] <= '0;
            end
        end else if (load) begin
            r_in_store[wr_idx]  <= n_in_lvl;
            r_out_store[wr_idx] <= n_out_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_ch      <= r_info.ch;
            r_out_in_lvl  <= n_in_lvl;
            r_out_out_lvl <= n_out_lvl;
            r_out_ovf     <= r_info.ovf;
        end
    end

    assign o_ack           = load;
    assign o_valid         = r_out_vld;
    assign o_level_channel = r_out_ch;
    assign o_input_level   = r_out_in_lvl;
    assign o_output_level  = r_out_out_lvl;
    assign o_overflow      = r_out_ovf;

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_st.done == i_out_st.done)
        else $error("lanes finished out of step");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!i_in_st.busy && !i_out_st.busy))
        else $error("block started while lanes busy");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_out_vld && !i_in_st.done))
        else $error("finished block not presented");

endmodule

`default_nettype wire

@@ src/block_rms_level_meter.sv @@
// ----------------------------------------------------------------------------
// block_rms_level_meter
// Per-channel RMS level meter with an input-side and an output-side lane.
// ----------------------------------------------------------------------------
// Throughput: one frame per cycle; a last frame is held off while the previous
//   block's levels are still being computed or wait for the output register.
// Flow: a non-last frame is squared into a register and then added to the
//   running sums; a last frame's result is set by the bit-serial divide and
//   square root in each lane, then held in the merge stage's output register.
// Reset (synchronous, active low): stopped, channel count 2, sums cleared, output empty.
`default_nettype none

module block_rms_level_meter
    import rms_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [CHAN_W-1:0]             i_channel,
    input  wire logic signed [SAMPLE_BITS-1:0] i_in_sample,
    input  wire logic                          i_in_present,
    input  wire logic signed [SAMPLE_BITS-1:0] i_out_sample,
    input  wire logic                          i_out_present,
    input  wire logic                          i_last_frame,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [CHAN_W-1:0]                  o_level_channel,
    output logic [LEVEL_W-1:0]                 o_input_level,
    output logic [LEVEL_W-1:0]                 o_output_level,
    output logic                               o_overflow,
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data
);

    logic                r_running;
    logic [CCOUNT_W-1:0] r_channel_count;

    logic                start;
    logic                release_blk;
    t_blk_info           blk_info;
    logic [SUM_W-1:0]    in_sum;
    logic [SUM_W-1:0]    out_sum;
    logic [TALLY_W-1:0]  tally;
    t_lane_st            in_st;
    t_lane_st            out_st;
    logic [SAMPLE_BITS-1:0] in_root;
    logic [SAMPLE_BITS-1:0] out_root;

    // Configuration registers; the user must write them only while the meter is idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running       <= 1'b0;
            r_channel_count <= CCOUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RUNNING:       r_running       <= i_cfg_data[0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: qualify each request, square and accumulate both sides.
    // On a last frame it hands the block sums and tally to the lanes and
    // clears its own state so the next block can start right away.
    rms_accum u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_running       (r_running),
        .i_channel_count (r_channel_count),
        .i_channel       (i_channel),
        .i_in_sample     (i_in_sample),
        .i_in_present    (i_in_present),
        .i_out_sample    (i_out_sample),
        .i_out_present   (i_out_present),
        .i_last_frame    (i_last_frame),
        .i_release       (release_blk),
        .o_start         (start),
        .o_info          (blk_info),
        .o_in_sum        (in_sum),
        .o_out_sum       (out_sum),
        .o_tally         (tally)
    );

    // Input-side lane: mean square, then floor root
    rms_lane u_lane_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (in_sum),
        .i_divisor  (tally),
        .i_ack      (release_blk),
        .o_st       (in_st),
        .o_root     (in_root)
    );

    // Output-side lane, running in lockstep with the input side
    rms_lane u_lane_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (out_sum),
        .i_divisor  (tally),
        .i_ack      (release_blk),
        .o_st       (out_st),
        .o_root     (out_root)
    );

    // Merge: pick new or stored level per side, update the stores and
    // hold the result until the consumer takes it
    rms_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_info          (blk_info),
        .i_in_st         (in_st),
        .i_out_st        (out_st),
        .i_in_root       (in_root),
        .i_out_root      (out_root),
        .o_ack           (release_blk),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_level_channel (o_level_channel),
        .o_input_level   (o_input_level),
        .o_output_level  (o_output_level),
        .o_overflow      (o_overflow)
    );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RMS level meter. Frames go in through the
// request channel, a local model of the meter predicts the levels of each
// finished block, and every result is compared field by field in order.
// ----------------------------------------------------------------------------

module tb_top;
    import rms_pkg::*;

    localparam int CLK_HALF       = 6;      // 12 ns period
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 120;
    localparam int STALL_CYCLES   = 600;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;   // cycles without any handshake
    localparam int MAX_REPORTS    = 10;
    localparam int SQ_BITS        = 2 * SAMPLE_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // One frame of one channel, as offered on the request channel
    typedef struct {
        logic [CHAN_W-1:0]             ch;
        logic signed [SAMPLE_BITS-1:0] in_s;
        logic                          in_p;
        logic signed [SAMPLE_BITS-1:0] out_s;
        logic                          out_p;
        logic                          last;
    } t_frame;

    // One reported set of levels
    typedef struct {
        logic [CHAN_W-1:0]  ch;
        logic [LEVEL_W-1:0] in_lvl;
        logic [LEVEL_W-1:0] out_lvl;
        logic               ovf;
    } t_levels;

    // ------------------------------------------------------------------------
    // DUT signals: every input starts at a known value
    // ------------------------------------------------------------------------
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_valid       = 1'b0;
    logic                          o_ready;
    logic [CHAN_W-1:0]             i_channel     = '0;
    logic signed [SAMPLE_BITS-1:0] i_in_sample   = '0;
    logic                          i_in_present  = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_out_sample  = '0;
    logic                          i_out_present = 1'b0;
    logic                          i_last_frame  = 1'b0;
    logic                          o_valid;
    logic                          i_ready       = 1'b0;
    logic [CHAN_W-1:0]             o_level_channel;
    logic [LEVEL_W-1:0]            o_input_level;
    logic [LEVEL_W-1:0]            o_output_level;
    logic                          o_overflow;
    logic                          i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data    = '0;

    block_rms_level_meter uut (.*);

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_frame  frame_queue[$];     // frames waiting to be offered
    t_levels level_expect[$];    // predicted results, oldest first
    t_frame  cur_frame;          // frame currently on the request port

    bit      req_taken     = 1'b0;  // request handshake seen at the last rising edge
    int      quiet_cycles  = 0;     // rising edges since the last handshake
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      stall_asks    = 0;     // bumped by the sequence to ask for a hold-off
    int      stall_seen    = 0;
    int      stall_left    = 0;

    int      n_requests    = 0;
    int      n_results     = 0;
    int      n_ovf_results = 0;
    int      n_errors      = 0;

    // Meter model: configuration, running sums and stored levels
    logic               run_en;
    logic [CCOUNT_W-1:0] chan_limit;
    logic [63:0]        in_acc;
    logic [63:0]        out_acc;
    int unsigned        tally;
    logic               ovf_flag;
    logic [LEVEL_W-1:0] in_store  [CHANNELS];
    logic [LEVEL_W-1:0] out_store [CHANNELS];

    // ------------------------------------------------------------------------
    // Meter model
    // ------------------------------------------------------------------------
    function automatic void meter_reset();
        run_en     = 1'b0;
        chan_limit = CCOUNT_RESET;
        in_acc     = '0;
        out_acc    = '0;
        tally      = 0;
        ovf_flag   = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            in_store[c]  = '0;
            out_store[c] = '0;
        end
    endfunction

    // Square of the magnitude; the most negative code squares to 2^46
    function automatic logic [SQ_BITS-1:0] sample_square(logic signed [SAMPLE_BITS-1:0] s);
        logic signed [SAMPLE_BITS:0] w;
        logic [SQ_BITS-1:0]          mag;
        w = s;
        if (w < 0)
            w = -w;
        mag = SQ_BITS'(unsigned'(w));
        return mag * mag;
    endfunction

    // Add and hold at all ones instead of wrapping
    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [SQ_BITS-1:0] b);
        logic [64:0] s;
        s = {1'b0, a} + 65'(b);
        return s[64] ? '1 : s[63:0];
    endfunction

    // Largest r with r*r <= x, built one bit at a time from the top
    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] trial;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= x)
                r = trial;
        end
        return r;
    endfunction

    // Advance the model by one accepted frame; queue the levels on a last frame
    task automatic predict_frame(input t_frame f);
        t_levels     r;
        logic [63:0] root;
        if (!run_en || f.ch >= chan_limit)
            return;
        if (tally < MAX_FRAMES) begin
            if (f.in_p)
                in_acc = sat_sum(in_acc, sample_square(f.in_s));
            if (f.out_p)
                out_acc = sat_sum(out_acc, sample_square(f.out_s));
            tally++;
        end else begin
            ovf_flag = 1'b1;
        end
        if (!f.last)
            return;
        if (tally != 0) begin
            // an absent side keeps what the channel had stored before
            if (f.in_p) begin
                root = floor_root(in_acc / tally);
                in_store[f.ch] = root[LEVEL_W-1:0];
            end
            if (f.out_p) begin
                root = floor_root(out_acc / tally);
                out_store[f.ch] = root[LEVEL_W-1:0];
            end
        end
        r.ch      = f.ch;
        r.in_lvl  = in_store[f.ch];
        r.out_lvl = out_store[f.ch];
        r.ovf     = ovf_flag;
        level_expect.push_back(r);
        in_acc   = '0;
        out_acc  = '0;
        tally    = 0;
        ovf_flag = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Rising edge: record both handshakes, predict, check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_levels want;
        bit      res_taken;
        req_taken = i_valid && o_ready;
        res_taken = o_valid && i_ready;
        if (i_rst_n) begin
            if (req_taken) begin
                predict_frame(cur_frame);
                n_requests++;
            end
            if (res_taken) begin
                n_results++;
                if (o_overflow)
                    n_ovf_results++;
                if (level_expect.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: unexpected result: ch %0d in %0d out %0d ovf %0d",
                                 $time, o_level_channel, o_input_level, o_output_level,
                                 o_overflow);
                end else begin
                    want = level_expect.pop_front();
                    if (want.ch != o_level_channel || want.in_lvl != o_input_level ||
                        want.out_lvl != o_output_level || want.ovf != o_overflow) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS) begin
                            $display("%0t: mismatch: expected ch %0d in %0d out %0d ovf %0d",
                                     $time, want.ch, want.in_lvl, want.out_lvl, want.ovf);
                            $display("%0t: mismatch: got      ch %0d in %0d out %0d ovf %0d",
                                     $time, o_level_channel, o_input_level, o_output_level,
                                     o_overflow);
                        end
                    end
                end
            end
            quiet_cycles = (req_taken || res_taken) ? 0 : quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: hold an offered frame until taken, then maybe idle
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !req_taken) begin
            // hold valid and payload until the meter takes the frame
        end else if (frame_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_frame = frame_queue.pop_front();
            i_channel     <= cur_frame.ch;
            i_in_sample   <= cur_frame.in_s;
            i_in_present  <= cur_frame.in_p;
            i_out_sample  <= cur_frame.out_s;
            i_out_present <= cur_frame.out_p;
            i_last_frame  <= cur_frame.last;
            i_valid       <= 1'b1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (stall_seen != stall_asks) begin
            stall_seen++;
            stall_left = STALL_CYCLES;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------------
    initial begin
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_frame(input logic [CHAN_W-1:0] ch,
                              input logic signed [SAMPLE_BITS-1:0] in_s, input logic in_p,
                              input logic signed [SAMPLE_BITS-1:0] out_s, input logic out_p,
                              input logic last);
        t_frame f;
        f = '{ch, in_s, in_p, out_s, out_p, last};
        frame_queue.push_back(f);
    endtask

    // Mostly full-range noise, with the extremes and tiny values mixed in
    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return SAMPLE_BITS'($signed($urandom_range(512)) - 256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic rand_present();
        return $urandom_range(99) < 85;
    endfunction

    task automatic queue_block(input logic [CHAN_W-1:0] ch, input int len);
        for (int k = 0; k < len; k++)
            push_frame(ch, rand_sample(), rand_present(), rand_sample(), rand_present(),
                       k == len - 1);
    endtask

    // Mostly well-formed blocks; some wander across channels, some are noise.
    // Only frames the meter does not ignore count toward the total.
    task automatic queue_random(input int count);
        int                live;
        int                pick;
        int                len;
        int                top;
        logic [CHAN_W-1:0] ch;
        live = 0;
        top  = (chan_limit > CHANNELS) ? CHANNELS : chan_limit;
        while (live < count) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 10);
                queue_block($urandom_range(top - 1), len);
                live += len;
            end else if (pick < 90) begin
                // sums are shared, the levels land on the last frame's channel
                len = $urandom_range(2, 8);
                for (int k = 0; k < len; k++)
                    push_frame($urandom_range(top - 1), rand_sample(), rand_present(),
                               rand_sample(), rand_present(), k == len - 1);
                live += len;
            end else begin
                ch = (top < CHANNELS) ? $urandom_range(CHANNELS - 1, top)
                                      : $urandom_range(CHANNELS - 1);
                push_frame(ch, rand_sample(), rand_present(), rand_sample(), rand_present(),
                           $urandom_range(1));
                if (ch < top)
                    live++;
            end
        end
    endtask

    // Wait until every frame is taken and every result checked, then let the
    // pipeline settle, since a frame without a result may still be in flight
    task automatic drain();
        while (frame_queue.size() != 0 || i_valid || level_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers change only while the meter is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_RUNNING)
            run_en = val[0];
        else
            chan_limit = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        meter_reset();
        send_idle_pct = 26;
        recv_idle_pct = 66;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // stopped after reset: both frames dropped
        push_frame(0, S_MAX, 1, S_MAX, 1, 0);
        push_frame(1, S_MIN, 1, S_MIN, 1, 1);
        write_reg(CFG_RUNNING, 1);
        // full scale: positive extreme in, negative extreme out
        push_frame(0, S_MAX, 1, S_MIN, 1, 1);
        // zero, one and minus one; means round down
        push_frame(1, 0, 1, -1, 1, 0);
        push_frame(1, 1, 1, -1, 1, 1);
        // input side absent all block: channel 0 keeps its input level
        push_frame(0, 24'h123456, 0, 4096, 1, 0);
        push_frame(0, S_MIN, 0, -4096, 1, 1);
        // output side absent only on the last frame: stored output level kept
        push_frame(1, 1000, 1, 555, 1, 0);
        push_frame(1, -1000, 1, 777, 0, 1);
        // channels at or above the reset channel count: dropped
        push_frame(2, S_MAX, 1, S_MAX, 1, 1);
        push_frame(7, S_MIN, 1, S_MIN, 1, 1);
        // block that starts on channel 0 and ends on channel 1
        push_frame(0, 3000, 1, -3000, 1, 0);
        push_frame(1, -7, 1, 9, 1, 1);
        // neither side present
        push_frame(0, 0, 0, 0, 0, 1);
        // channel count zero: everything dropped
        write_reg(CFG_CHANNEL_COUNT, 0);
        push_frame(0, S_MAX, 1, S_MAX, 1, 1);
        // channel count above the channel total: all channels live
        write_reg(CFG_CHANNEL_COUNT, 15);
        push_frame(7, S_MIN, 1, 12345, 1, 1);
        push_frame(5, 24'h555555, 1, 24'hAAAAAA, 1, 1);
        push_frame(6, 24'hAAAAAA, 1, 24'h555555, 1, 1);

        // --- random, sender idles a little, receiver a lot ---
        write_reg(CFG_CHANNEL_COUNT, CHANNELS);
        queue_random(430);

        // long receiver hold-off with many short blocks queued: the output
        // register fills and the meter must hold off the next last frame
        for (int k = 0; k < 16; k++)
            queue_block($urandom_range(CHANNELS - 1), $urandom_range(1, 3));
        stall_asks++;
        // sender pauses here until every result is back
        drain();

        // --- random, sender idles a lot, receiver a little ---
        send_idle_pct = 66;
        recv_idle_pct = 26;
        write_reg(CFG_CHANNEL_COUNT, 3);
        queue_random(430);

        // stop, offer a few frames that must be dropped, then resume
        write_reg(CFG_RUNNING, 0);
        for (int k = 0; k < 4; k++)
            push_frame(k, rand_sample(), 1, rand_sample(), 1, k[0]);
        write_reg(CFG_RUNNING, 1);

        // --- random, no idling on either side ---
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_CHANNEL_COUNT, 1);
        queue_random(150);
        write_reg(CFG_CHANNEL_COUNT, CHANNELS);
        queue_random(280);
        queue_block(2, 3);

        drain();
        $display("covered %0d accepted frames and %0d level results, %0d with overflow",
                 n_requests, n_results, n_ovf_results);
        $display("channel counts 0, 1, 2, 3, 8 and 15, stopped and running, three idle mixes");
        if (n_errors == 0 && level_expect.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
